### rtl/core/ap3d_pkg.sv
// Shared constants, types and functions of the 3D corner-turn engine.
package ap3d_pkg;

    localparam int MAX_ELEMS  = 4096;
    localparam int DATA_WIDTH = 32;
    localparam int FIELD_W    = 32;
    localparam int DIM_W      = 13;
    localparam int MODE_W     = 3;
    localparam int ADDR_W     = $clog2(MAX_ELEMS);
    localparam int CNT_W      = $clog2(MAX_ELEMS + 1);
    localparam int SAT_W      = $clog2(MAX_ELEMS + 2);
    localparam int CMP_W      = (DIM_W > SAT_W) ? DIM_W : SAT_W;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = DIM_W;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_NUM_SECS     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_PERMUTE_MODE = CFG_IDX_W'(3);

    // Permutation modes, named by output axis order.
    localparam logic [MODE_W-1:0] MODE_123 = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_132 = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_213 = MODE_W'(2);
    localparam logic [MODE_W-1:0] MODE_231 = MODE_W'(3);
    localparam logic [MODE_W-1:0] MODE_312 = MODE_W'(4);
    localparam logic [MODE_W-1:0] MODE_321 = MODE_W'(5);

    // Source axes.
    localparam logic [1:0] AX_ROW = 2'd0;
    localparam logic [1:0] AX_COL = 2'd1;
    localparam logic [1:0] AX_SEC = 2'd2;

    // Item opcodes.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_MODE   = 2'd1,
        ST_BAD_SIZE   = 2'd2,
        ST_INCOMPLETE = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0] outer;
        logic [1:0] middle;
        logic [1:0] inner;
    } axes_t;

    // Configuration write as seen by the register block.
    typedef struct packed {
        logic                  wr;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    // Geometry and mode handed from the register block to the controller.
    typedef struct packed {
        logic [DIM_W-1:0]  num_rows;
        logic [DIM_W-1:0]  num_cols;
        logic [DIM_W-1:0]  num_secs;
        logic [MODE_W-1:0] mode;
        logic [CMP_W-1:0]  row_stride;
        logic [CNT_W-1:0]  total;
        logic              total_ok;
        logic              mode_ok;
        logic              pending;
        logic              clear;
    } geom_t;

    // Buffer access requested by the controller.
    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     waddr;
        logic [DATA_WIDTH-1:0] wdata;
        logic [ADDR_W-1:0]     raddr;
    } mem_req_t;

    // Result of a drain item, before the buffer data joins it.
    typedef struct packed {
        logic    is_drain;
        status_t status;
        logic    last;
    } drain_t;

    // Output axis order per mode: slowest, middle, fastest.
    function automatic axes_t axis_order(logic [MODE_W-1:0] mode);
        axes_t ax;
        unique case (mode)
            MODE_132: ax = '{AX_ROW, AX_SEC, AX_COL};
            MODE_213: ax = '{AX_COL, AX_ROW, AX_SEC};
            MODE_231: ax = '{AX_COL, AX_SEC, AX_ROW};
            MODE_312: ax = '{AX_SEC, AX_ROW, AX_COL};
            MODE_321: ax = '{AX_SEC, AX_COL, AX_ROW};
            default:  ax = '{AX_ROW, AX_COL, AX_SEC};
        endcase
        return ax;
    endfunction

endpackage

### rtl/core/ap3d_if.sv
// Channel interfaces of the 3D corner-turn engine: items, results, configuration.
interface ap3d_in_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [ap3d_pkg::FIELD_W-1:0] load_data;

    modport source (output valid, opcode, load_data, input ready);
    modport sink   (input valid, opcode, load_data, output ready);
endinterface

interface ap3d_out_if;
    logic                        valid;
    logic                        ready;
    logic [ap3d_pkg::FIELD_W-1:0] out_data;
    logic                        last_element;
    ap3d_pkg::status_t           status;

    modport source (output valid, out_data, last_element, status, input ready);
    modport sink   (input valid, out_data, last_element, status, output ready);
endinterface

interface ap3d_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ap3d_pkg::CFG_IDX_W-1:0]  index;
    logic [ap3d_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/ap3d_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ap3d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/ap3d_cfg.sv
// Configuration registers and the geometry products derived from them.
module ap3d_cfg (
    input  logic              clk,
    input  logic              rst_n,
    input  ap3d_pkg::cfg_wr_t cfg_wr,
    output ap3d_pkg::geom_t   geom
);

    localparam int PROD_W = ap3d_pkg::DIM_W + ap3d_pkg::CMP_W;

    logic [ap3d_pkg::DIM_W-1:0]  rows_reg, rows_next;
    logic [ap3d_pkg::DIM_W-1:0]  cols_reg, cols_next;
    logic [ap3d_pkg::DIM_W-1:0]  secs_reg, secs_next;
    logic [ap3d_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [ap3d_pkg::CMP_W-1:0]  cs_reg, cs_next;
    logic [ap3d_pkg::CNT_W-1:0]  total_reg, total_next;
    logic                        total_ok_reg, total_ok_next;
    logic                        pend1_reg, pend1_next;
    logic                        pend2_reg, pend2_next;
    logic                        known_index;
    logic [2*ap3d_pkg::DIM_W-1:0] cs_full;
    logic [PROD_W-1:0]           total_full;

    always_comb
    begin
        rows_next   = rows_reg;
        cols_next   = cols_reg;
        secs_next   = secs_reg;
        mode_next   = mode_reg;
        known_index = 1'b1;
        unique case (cfg_wr.index)
            ap3d_pkg::REG_NUM_ROWS:     rows_next = cfg_wr.wr ? cfg_wr.data : rows_reg;
            ap3d_pkg::REG_NUM_COLS:     cols_next = cfg_wr.wr ? cfg_wr.data : cols_reg;
            ap3d_pkg::REG_NUM_SECS:     secs_next = cfg_wr.wr ? cfg_wr.data : secs_reg;
            ap3d_pkg::REG_PERMUTE_MODE:
                mode_next = cfg_wr.wr ? cfg_wr.data[ap3d_pkg::MODE_W-1:0] : mode_reg;
            default:                    known_index = 1'b0;
        endcase

        // Two-step product: columns times sections first, then rows.
        cs_full = (2*ap3d_pkg::DIM_W)'(cols_reg) * (2*ap3d_pkg::DIM_W)'(secs_reg);
        if (cs_full > (2*ap3d_pkg::DIM_W)'(ap3d_pkg::MAX_ELEMS))
        begin
            cs_next = ap3d_pkg::CMP_W'(ap3d_pkg::MAX_ELEMS + 1);
        end
        else
        begin
            cs_next = ap3d_pkg::CMP_W'(cs_full);
        end
        if (!pend1_reg)
        begin
            cs_next = cs_reg;
        end

        total_full    = PROD_W'(rows_reg) * PROD_W'(cs_reg);
        total_next    = total_reg;
        total_ok_next = total_ok_reg;
        if (pend2_reg)
        begin
            total_next    = ap3d_pkg::CNT_W'(total_full);
            total_ok_next = (rows_reg != '0) && (cols_reg != '0) && (secs_reg != '0)
                            && (total_full <= PROD_W'(ap3d_pkg::MAX_ELEMS));
        end

        pend1_next = cfg_wr.wr && known_index;
        pend2_next = pend1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg     <= ap3d_pkg::DIM_W'(1);
            cols_reg     <= ap3d_pkg::DIM_W'(1);
            secs_reg     <= ap3d_pkg::DIM_W'(1);
            mode_reg     <= ap3d_pkg::MODE_213;
            cs_reg       <= ap3d_pkg::CMP_W'(1);
            total_reg    <= ap3d_pkg::CNT_W'(1);
            total_ok_reg <= 1'b1;
            pend1_reg    <= 1'b0;
            pend2_reg    <= 1'b0;
        end
        else
        begin
            rows_reg     <= rows_next;
            cols_reg     <= cols_next;
            secs_reg     <= secs_next;
            mode_reg     <= mode_next;
            cs_reg       <= cs_next;
            total_reg    <= total_next;
            total_ok_reg <= total_ok_next;
            pend1_reg    <= pend1_next;
            pend2_reg    <= pend2_next;
        end
    end

    assign geom.num_rows   = rows_reg;
    assign geom.num_cols   = cols_reg;
    assign geom.num_secs   = secs_reg;
    assign geom.mode       = mode_reg;
    assign geom.row_stride = cs_reg;
    assign geom.total      = total_reg;
    assign geom.total_ok   = total_ok_reg;
    assign geom.mode_ok    = (mode_reg >= ap3d_pkg::MODE_132) && (mode_reg <= ap3d_pkg::MODE_321);
    assign geom.pending    = pend1_reg || pend2_reg;
    assign geom.clear      = cfg_wr.wr && known_index;

endmodule

### rtl/core/ap3d_ctrl.sv
// Load and drain counters, incremental address generation and drain status.
module ap3d_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ap3d_pkg::geom_t                   geom,
    input  logic                              accept,
    input  logic                              opcode,
    input  logic [ap3d_pkg::FIELD_W-1:0]      load_data,
    output ap3d_pkg::mem_req_t                mem_req,
    output ap3d_pkg::drain_t                  drain
);

    localparam int SUM_W = ap3d_pkg::CMP_W + 1;

    logic [ap3d_pkg::CNT_W-1:0]  load_count_reg, load_count_next;
    logic [ap3d_pkg::CNT_W-1:0]  drain_count_reg, drain_count_next;
    logic [ap3d_pkg::ADDR_W-1:0] outer_reg, outer_next;
    logic [ap3d_pkg::ADDR_W-1:0] middle_reg, middle_next;
    logic [ap3d_pkg::ADDR_W-1:0] inner_reg, inner_next;
    logic [ap3d_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [ap3d_pkg::ADDR_W-1:0] mid_base_reg, mid_base_next;
    logic [ap3d_pkg::ADDR_W-1:0] out_base_reg, out_base_next;

    ap3d_pkg::axes_t            ax;
    logic [ap3d_pkg::CMP_W-1:0] size_m, size_i;
    logic [ap3d_pkg::CMP_W-1:0] str_o, str_m, str_i;
    logic [SUM_W-1:0]           addr_step, mid_step, out_step;
    logic                       inner_wrap, mid_wrap;
    logic                       load_ok, last;
    ap3d_pkg::status_t          status;

    function automatic logic [ap3d_pkg::CMP_W-1:0] axis_size(ap3d_pkg::geom_t g,
                                                              logic [1:0] a);
        logic [ap3d_pkg::CMP_W-1:0] s;
        unique case (a)
            ap3d_pkg::AX_ROW: s = ap3d_pkg::CMP_W'(g.num_rows);
            ap3d_pkg::AX_COL: s = ap3d_pkg::CMP_W'(g.num_cols);
            default:          s = ap3d_pkg::CMP_W'(g.num_secs);
        endcase
        return s;
    endfunction

    function automatic logic [ap3d_pkg::CMP_W-1:0] axis_stride(ap3d_pkg::geom_t g,
                                                                logic [1:0] a);
        logic [ap3d_pkg::CMP_W-1:0] s;
        unique case (a)
            ap3d_pkg::AX_ROW: s = g.row_stride;
            ap3d_pkg::AX_COL: s = ap3d_pkg::CMP_W'(g.num_secs);
            default:          s = ap3d_pkg::CMP_W'(1);
        endcase
        return s;
    endfunction

    always_comb
    begin
        ax     = ap3d_pkg::axis_order(geom.mode);
        size_m = axis_size(geom, ax.middle);
        size_i = axis_size(geom, ax.inner);
        str_o  = axis_stride(geom, ax.outer);
        str_m  = axis_stride(geom, ax.middle);
        str_i  = axis_stride(geom, ax.inner);

        addr_step = SUM_W'(addr_reg) + SUM_W'(str_i);
        mid_step  = SUM_W'(mid_base_reg) + SUM_W'(str_m);
        out_step  = SUM_W'(out_base_reg) + SUM_W'(str_o);

        inner_wrap = (ap3d_pkg::CMP_W'(inner_reg) + ap3d_pkg::CMP_W'(1)) >= size_i;
        mid_wrap   = (ap3d_pkg::CMP_W'(middle_reg) + ap3d_pkg::CMP_W'(1)) >= size_m;

        load_ok = geom.total_ok && (load_count_reg < geom.total);
        last    = (drain_count_reg + ap3d_pkg::CNT_W'(1)) == geom.total;

        priority if (!geom.mode_ok)
        begin
            status = ap3d_pkg::ST_BAD_MODE;
        end
        else if (!geom.total_ok)
        begin
            status = ap3d_pkg::ST_BAD_SIZE;
        end
        else if (load_count_reg < geom.total)
        begin
            status = ap3d_pkg::ST_INCOMPLETE;
        end
        else
        begin
            status = ap3d_pkg::ST_OK;
        end

        load_count_next  = load_count_reg;
        drain_count_next = drain_count_reg;
        outer_next       = outer_reg;
        middle_next      = middle_reg;
        inner_next       = inner_reg;
        addr_next        = addr_reg;
        mid_base_next    = mid_base_reg;
        out_base_next    = out_base_reg;

        priority if (geom.clear)
        begin
            load_count_next  = '0;
            drain_count_next = '0;
            outer_next       = '0;
            middle_next      = '0;
            inner_next       = '0;
            addr_next        = '0;
            mid_base_next    = '0;
            out_base_next    = '0;
        end
        else if (accept && (opcode == ap3d_pkg::OP_LOAD))
        begin
            if (load_ok)
            begin
                load_count_next = load_count_reg + ap3d_pkg::CNT_W'(1);
            end
        end
        else if (accept && (status == ap3d_pkg::ST_OK))
        begin
            if (last)
            begin
                // The final element empties the engine for the next array.
                load_count_next  = '0;
                drain_count_next = '0;
                outer_next       = '0;
                middle_next      = '0;
                inner_next       = '0;
                addr_next        = '0;
                mid_base_next    = '0;
                out_base_next    = '0;
            end
            else
            begin
                drain_count_next = drain_count_reg + ap3d_pkg::CNT_W'(1);
                if (!inner_wrap)
                begin
                    inner_next = inner_reg + ap3d_pkg::ADDR_W'(1);
                    addr_next  = addr_step[ap3d_pkg::ADDR_W-1:0];
                end
                else if (!mid_wrap)
                begin
                    inner_next    = '0;
                    middle_next   = middle_reg + ap3d_pkg::ADDR_W'(1);
                    mid_base_next = mid_step[ap3d_pkg::ADDR_W-1:0];
                    addr_next     = mid_step[ap3d_pkg::ADDR_W-1:0];
                end
                else
                begin
                    inner_next    = '0;
                    middle_next   = '0;
                    outer_next    = outer_reg + ap3d_pkg::ADDR_W'(1);
                    out_base_next = out_step[ap3d_pkg::ADDR_W-1:0];
                    mid_base_next = out_step[ap3d_pkg::ADDR_W-1:0];
                    addr_next     = out_step[ap3d_pkg::ADDR_W-1:0];
                end
            end
        end
        else
        begin
            load_count_next = load_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count_reg  <= '0;
            drain_count_reg <= '0;
            outer_reg       <= '0;
            middle_reg      <= '0;
            inner_reg       <= '0;
            addr_reg        <= '0;
            mid_base_reg    <= '0;
            out_base_reg    <= '0;
        end
        else
        begin
            load_count_reg  <= load_count_next;
            drain_count_reg <= drain_count_next;
            outer_reg       <= outer_next;
            middle_reg      <= middle_next;
            inner_reg       <= inner_next;
            addr_reg        <= addr_next;
            mid_base_reg    <= mid_base_next;
            out_base_reg    <= out_base_next;
        end
    end

    assign mem_req.we    = accept && (opcode == ap3d_pkg::OP_LOAD) && load_ok && !geom.clear;
    assign mem_req.waddr = load_count_reg[ap3d_pkg::ADDR_W-1:0];
    assign mem_req.wdata = ap3d_pkg::DATA_WIDTH'(load_data);
    assign mem_req.raddr = addr_reg;

    assign drain.is_drain = accept && (opcode == ap3d_pkg::OP_DRAIN);
    assign drain.status   = status;
    assign drain.last     = last && (status == ap3d_pkg::ST_OK);

endmodule

### rtl/core/array_axis_permute_3d_unit.sv
// Top level of the 3D corner-turn engine: channels, buffer and result pipeline.
//
// The engine turns a rows x columns x sections array, delivered row-major with
// sections fastest, into one of five permuted axis orders. Each item on the
// items channel is either a load, which writes the next source element into
// the buffer and produces no result, or a drain, which produces exactly one
// result item on the results channel: the next element in permuted order,
// with last_element set on the final one, or a zero element with an error
// status (bad mode, bad geometry, or a drain before the load is complete).
// The configuration channel writes num_rows, num_cols, num_secs and
// permute_mode; it is always ready, and any write to a known register aborts
// the array in progress. After a write the items channel holds ready low
// while the element count is recomputed by two multipliers. Throughput is
// one item per cycle, unless the recompute or a receiver stall holds it
// back. A drain result passes the registered buffer read and then the
// output register. When the receiver stalls, the whole two-stage result
// pipeline holds, and items ready drops until the output register is taken.
// Reset empties the engine and restores a 1 x 1 x 1 array in mode 213; the
// buffer contents are not cleared, as only freshly loaded entries are read.
module array_axis_permute_3d_unit (
    input logic        clk,
    input logic        rst_n,
    ap3d_cfg_if.sink   cfg,
    ap3d_in_if.sink    items,
    ap3d_out_if.source results
);

    ap3d_pkg::cfg_wr_t  cfg_wr;
    ap3d_pkg::geom_t    geom;
    ap3d_pkg::mem_req_t mem_req;
    ap3d_pkg::drain_t   drain;

    logic                           advance;
    logic                           accept;
    logic [ap3d_pkg::DATA_WIDTH-1:0] rdata;

    // Stage one: the buffer read is in flight.
    logic              s1_valid_reg;
    ap3d_pkg::status_t s1_status_reg;
    logic              s1_last_reg;

    // Stage two: the output register.
    logic                         out_valid_reg;
    logic [ap3d_pkg::FIELD_W-1:0] out_data_reg;
    logic                         out_last_reg;
    ap3d_pkg::status_t            out_status_reg;

    // The configuration port never stalls.
    assign cfg.ready    = 1'b1;
    assign cfg_wr.wr    = cfg.valid;
    assign cfg_wr.index = cfg.index;
    assign cfg_wr.data  = cfg.data;

    // The pipeline moves as a whole whenever the output register is free or
    // being taken, and a new item may enter exactly then.
    assign advance     = !out_valid_reg || results.ready;
    assign items.ready = advance && !geom.pending;
    assign accept      = items.valid && items.ready;

    ap3d_cfg u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_wr (cfg_wr),
        .geom   (geom)
    );

    ap3d_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .geom      (geom),
        .accept    (accept),
        .opcode    (items.opcode),
        .load_data (items.load_data),
        .mem_req   (mem_req),
        .drain     (drain)
    );

    // The read port is enabled only when the pipeline advances, so the read
    // data stays with its item while the receiver stalls.
    ap3d_ram #(
        .WIDTH (ap3d_pkg::DATA_WIDTH),
        .DEPTH (ap3d_pkg::MAX_ELEMS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (advance),
        .raddr (mem_req.raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s1_status_reg  <= ap3d_pkg::ST_OK;
            s1_last_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            out_last_reg   <= 1'b0;
            out_status_reg <= ap3d_pkg::ST_OK;
        end
        else if (advance)
        begin
            s1_valid_reg   <= drain.is_drain;
            s1_status_reg  <= drain.status;
            s1_last_reg    <= drain.last;
            out_valid_reg  <= s1_valid_reg;
            out_last_reg   <= s1_last_reg;
            out_status_reg <= s1_status_reg;
            // An error result carries a zero element.
            if (s1_status_reg == ap3d_pkg::ST_OK)
            begin
                out_data_reg <= ap3d_pkg::FIELD_W'(rdata);
            end
            else
            begin
                out_data_reg <= '0;
            end
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.out_data     = out_data_reg;
    assign results.last_element = out_last_reg;
    assign results.status       = out_status_reg;

    // No item enters while the element count is being recomputed.
    a_pending_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        geom.pending |-> !items.ready)
        else $error("items accepted during geometry update");

    // An error result has a zero element and no last marker.
    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && (results.status != ap3d_pkg::ST_OK))
        |-> ((results.out_data == '0) && !results.last_element))
        else $error("error result carries data or last marker");

    // A load item never turns into a result.
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (items.opcode == ap3d_pkg::OP_LOAD)) |=> !s1_valid_reg)
        else $error("load item produced a result");

    // A stalled read stage keeps its item.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(s1_status_reg)
                                         && $stable(s1_last_reg)))
        else $error("read stage lost its item during a stall");

endmodule
